[design/hla_pkg.sv]
// hla_pkg: shared types, widths, reset values and the sine/cosine generator
// for the hough line accumulator
// depends on nothing
package hla_pkg;

  localparam int THETA_BINS_DEF = 315;
  localparam int RHO_BINS_DEF   = 1024;

  localparam int OP_W   = 2;
  localparam int PIX_W  = 9;
  localparam int EDGE_W = 8;
  localparam int RB_W   = 10;
  localparam int TB_W   = 9;
  localparam int CNT_W  = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int STEP_W = 8;
  localparam int RMAX_W = 9;
  localparam logic [STEP_W-1:0] STEP_RST = 8'd16;
  localparam logic [RMAX_W-1:0] RMAX_RST = 9'd363;

  localparam int PADDR_W = 3;
  localparam int DATA_W  = 32;

  localparam int TRIG_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int D_SHIFT = 10;
  localparam int M_SHIFT = 11;
  localparam int PA_W    = PIX_W + 1 + TRIG_W;
  localparam int NUM_W   = 28;
  localparam int MUL_M_W = 15;

  localparam int RECIP_K = 24;
  localparam int RECIP_W = RECIP_K + 1;
  localparam int PROD_W  = MUL_M_W + RECIP_W;
  localparam int RMAX_SHIFT = 5;
  localparam int RM32_W  = RMAX_W + RMAX_SHIFT;
  localparam int BP_W    = RM32_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_RST =
    RECIP_W'(((1 << RECIP_K) - 1) / int'(STEP_RST) + 1);
  localparam int BINS_RST_RAW = (int'(RMAX_RST) * 32) / int'(STEP_RST) + 1;

  localparam longint Q30 = longint'(1) << 30;

  typedef enum logic [OP_W-1:0] {
    OP_VOTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_STEP = 1'b0,
    REG_RMAX = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ
  } state_e;

  typedef enum logic [1:0] {
    RC_IDLE,
    RC_DIV,
    RC_MUL,
    RC_FIN
  } rc_state_e;

  function automatic longint mul_q30(longint a, longint b);
    return (a * b) / Q30;
  endfunction

  // series term index divide, each arm by a fixed divisor
  function automatic longint div_term(longint t, int k);
    longint r;
    unique case (k)
      2:       r = t / 2;
      3:       r = t / 3;
      4:       r = t / 4;
      5:       r = t / 5;
      6:       r = t / 6;
      7:       r = t / 7;
      8:       r = t / 8;
      9:       r = t / 9;
      10:      r = t / 10;
      11:      r = t / 11;
      12:      r = t / 12;
      13:      r = t / 13;
      14:      r = t / 14;
      default: r = t;
    endcase
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] q30_to_q14(longint v);
    longint r;
    if (v >= 0) begin
      r = (v + 32768) / 65536;
    end else begin
      r = -((-v + 32768) / 65536);
    end
    return TRIG_W'(r);
  endfunction

  // taylor series at theta/16, then four angle doublings
  function automatic logic signed [TRIG_W-1:0] trig_q14(int j, bit want_sin);
    longint a;
    longint term;
    longint c;
    longint s;
    longint ns;
    longint nc;
    a = (longint'(j) * 67108864 + 50) / 100;
    term = Q30;
    c = Q30;
    s = 0;
    for (int k = 1; k <= 14; k++) begin
      term = div_term(mul_q30(term, a), k);
      unique case (k & 3)
        1: s = s + term;
        2: c = c - term;
        3: s = s - term;
        default: c = c + term;
      endcase
    end
    for (int n = 0; n < 4; n++) begin
      ns = 2 * mul_q30(s, c);
      nc = 2 * mul_q30(c, c) - Q30;
      s = ns;
      c = nc;
    end
    return want_sin ? q30_to_q14(s) : q30_to_q14(c);
  endfunction

endpackage

[design/hla_trig_rom.sv]
// hla_trig_rom: q1.14 cosine and sine table per theta bin, registered read
// depends on hla_pkg
module hla_trig_rom import hla_pkg::*; #(
  parameter int THETA_BINS = THETA_BINS_DEF,
  localparam int TW = (THETA_BINS > 1) ? $clog2(THETA_BINS) : 1
) (
  input  logic                     clk_i,
  input  logic [TW-1:0]            idx_i,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [TRIG_W-1:0] cos_tab [THETA_BINS];
  logic signed [TRIG_W-1:0] sin_tab [THETA_BINS];

  for (genvar g = 0; g < THETA_BINS; g++) begin : g_tab
    localparam logic signed [TRIG_W-1:0] CosVal = trig_q14(g, 1'b0);
    localparam logic signed [TRIG_W-1:0] SinVal = trig_q14(g, 1'b1);
    assign cos_tab[g] = CosVal;
    assign sin_tab[g] = SinVal;
  end

  always_ff @(posedge clk_i) begin
    cos_o <= cos_tab[idx_i];
    sin_o <= sin_tab[idx_i];
  end

endmodule

[design/hla_recip.sv]
// hla_recip: serial reciprocal of the rho step and the count of rho bins in use
// depends on hla_pkg
module hla_recip import hla_pkg::*; #(
  parameter int RHO_BINS = RHO_BINS_DEF,
  localparam int BW = $clog2(RHO_BINS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [STEP_W-1:0]  step_i,
  input  logic [RMAX_W-1:0]  rmax_i,
  output logic               busy_o,
  output logic [RECIP_W-1:0] recip_o,
  output logic [BW-1:0]      bins_o
);

  localparam int CW = $clog2(RECIP_K);
  localparam logic [BW-1:0] BINS_RST =
    BW'((BINS_RST_RAW > RHO_BINS) ? RHO_BINS : BINS_RST_RAW);

  rc_state_e state_q, state_d;
  logic [CW-1:0]      cnt_q;
  logic [STEP_W-1:0]  rem_q;
  logic [RECIP_K-1:0] quo_q;
  logic [RECIP_W-1:0] recip_q;
  logic [BW-1:0]      bins_q;

  logic [STEP_W:0]    trial;
  logic               ge;
  logic [STEP_W-1:0]  rem_d;
  logic [BP_W-1:0]    bprod;
  logic [BP_W-RECIP_K:0] braw;
  logic [BW-1:0]      bins_d;

  always_comb begin
    state_d = state_q;
    if (start_i) begin
      state_d = RC_DIV;
    end else begin
      unique case (state_q)
        RC_IDLE: state_d = RC_IDLE;
        RC_DIV:  if (cnt_q == CW'(RECIP_K - 1)) state_d = RC_MUL;
        RC_MUL:  state_d = RC_FIN;
        RC_FIN:  state_d = RC_IDLE;
        default: state_d = RC_IDLE;
      endcase
    end
  end

  always_comb begin
    busy_o  = (state_q != RC_IDLE);
    recip_o = recip_q;
    bins_o  = bins_q;
  end

  // restoring division of all ones by the step, one bit a cycle
  always_comb begin
    trial = {rem_q, 1'b1};
    ge    = (trial >= {1'b0, step_i});
    rem_d = ge ? STEP_W'(trial - {1'b0, step_i}) : trial[STEP_W-1:0];
    bprod = {rmax_i, {RMAX_SHIFT{1'b0}}} * recip_q;
    braw  = {1'b0, bprod[BP_W-1:RECIP_K]} + 1'b1;
    bins_d = (braw > (BP_W - RECIP_K + 1)'(RHO_BINS)) ? BW'(RHO_BINS) : braw[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RC_IDLE;
      cnt_q   <= '0;
      recip_q <= RECIP_RST;
      bins_q  <= BINS_RST;
    end else begin
      state_q <= state_d;
      if (start_i) begin
        cnt_q <= '0;
      end else if (state_q == RC_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (!start_i && state_q == RC_MUL) begin
        recip_q <= {1'b0, quo_q} + 1'b1;
      end
      if (!start_i && state_q == RC_FIN) begin
        bins_q <= bins_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (state_q == RC_DIV) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[RECIP_K-2:0], ge};
    end
  end

endmodule

[design/hla_rho_calc.sv]
// hla_rho_calc: pipelined rho bin of one theta bin per cycle, with range check
// depends on hla_pkg
module hla_rho_calc import hla_pkg::*; #(
  parameter int THETA_BINS = THETA_BINS_DEF,
  parameter int RHO_BINS   = RHO_BINS_DEF,
  localparam int TW = (THETA_BINS > 1) ? $clog2(THETA_BINS) : 1,
  localparam int RW = $clog2(RHO_BINS),
  localparam int BW = $clog2(RHO_BINS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     v_i,
  input  logic [TW-1:0]            theta_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  logic [PIX_W-1:0]         x_i,
  input  logic [PIX_W-1:0]         y_i,
  input  logic [RMAX_W-1:0]        rmax_i,
  input  logic [STEP_W-1:0]        step_i,
  input  logic [RECIP_W-1:0]       recip_i,
  input  logic [BW-1:0]            bins_i,
  output logic                     v_o,
  output logic [TW-1:0]            theta_o,
  output logic [RW-1:0]            rho_o,
  output logic                     active_o
);

  localparam int Q_W = PROD_W - RECIP_K;

  logic va_q, vb_q, vc_q, vd_q;
  logic [TW-1:0] ta_q, tb_q, tc_q;
  logic signed [PA_W-1:0] px_d, py_d, px_q, py_q;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0] mag;
  logic [NUM_W:0] np;
  logic [MUL_M_W-1:0] m_d, m_q;
  logic neg_b_q, neg_c_q;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [Q_W-1:0] q;
  logic ok;
  logic [RW-1:0] rho_q;
  logic [TW-1:0] td_q;

  always_comb begin
    px_d = $signed({1'b0, x_i}) * cos_i;
    py_d = $signed({1'b0, y_i}) * sin_i;
    num  = {{(NUM_W-PA_W){px_q[PA_W-1]}}, px_q}
         + {{(NUM_W-PA_W){py_q[PA_W-1]}}, py_q}
         + {{(NUM_W-RMAX_W-FRAC_W){1'b0}}, rmax_i, {FRAC_W{1'b0}}};
    mag  = num[NUM_W-1] ? NUM_W'(-num) : num;
    // 2*|num| + d, then drop the 2048 common to both sides of the quotient
    np   = {mag, 1'b0} + {{(NUM_W+1-STEP_W-D_SHIFT){1'b0}}, step_i, {D_SHIFT{1'b0}}};
    m_d  = np[MUL_M_W+M_SHIFT-1:M_SHIFT];
    prod_d = m_q * recip_i;
    q    = prod_q[PROD_W-1:RECIP_K];
    ok   = neg_c_q ? (q == '0) : (q < Q_W'(bins_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= v_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q & ok;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    ta_q    <= theta_i;
    m_q     <= m_d;
    neg_b_q <= num[NUM_W-1];
    tb_q    <= ta_q;
    prod_q  <= prod_d;
    neg_c_q <= neg_b_q;
    tc_q    <= tb_q;
    rho_q   <= q[RW-1:0];
    td_q    <= tc_q;
  end

  assign v_o      = vd_q;
  assign theta_o  = td_q;
  assign rho_o    = rho_q;
  assign active_o = va_q | vb_q | vc_q | vd_q;

endmodule

[design/hla_vote_store.sv]
// hla_vote_store: vote count memory with saturating read-modify-write and clear writes
// depends on hla_pkg
module hla_vote_store import hla_pkg::*; #(
  parameter int THETA_BINS = THETA_BINS_DEF,
  parameter int RHO_BINS   = RHO_BINS_DEF,
  localparam int TW = (THETA_BINS > 1) ? $clog2(THETA_BINS) : 1,
  localparam int RW = $clog2(RHO_BINS),
  localparam int AW = TW + RW,
  localparam int DEPTH = THETA_BINS * (1 << RW)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             inc_v_i,
  input  logic [AW-1:0]    inc_addr_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             clr_en_i,
  input  logic [AW-1:0]    clr_addr_i,
  output logic [CNT_W-1:0] rd_data_o,
  output logic             pending_o
);

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rdata_q;
  logic             inc_v_q;
  logic [AW-1:0]    inc_addr_q;
  logic             ren;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [CNT_W-1:0] wdata;

  always_comb begin
    ren   = rd_en_i | inc_v_i;
    raddr = inc_v_i ? inc_addr_i : rd_addr_i;
    we    = clr_en_i | inc_v_q;
    waddr = clr_en_i ? clr_addr_i : inc_addr_q;
    if (clr_en_i) begin
      wdata = '0;
    end else if (rdata_q == CNT_MAX) begin
      wdata = rdata_q;
    end else begin
      wdata = rdata_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_v_q <= 1'b0;
    end else begin
      inc_v_q <= inc_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    inc_addr_q <= inc_addr_i;
  end

  assign rd_data_o = rdata_q;
  assign pending_o = inc_v_q;

endmodule

[design/hough_line_accumulator_top.sv]
// hough_line_accumulator_top: command interface, apb registers and sequencer
// depends on hla_pkg, hla_trig_rom, hla_recip, hla_rho_calc, hla_vote_store
//
//   channel   signals                                    direction
//   command   start, busy, op_i, pixel_*, edge, bins     in (busy out)
//   result    result_valid_o, bin_count_o, bin_missing_o out, one-cycle strobe
//   config    psel, penable, pwrite, paddr, pwdata, ...  apb, pready always high
//
// vote: busy after the item until the last theta bin has been written; one theta bin per
//   cycle through rom, rho pipe and the store read-modify-write, items one at a time
// read: result strobe the cycle after the item; clear and reset sweep
//   THETA_BINS * 2**clog2(RHO_BINS) entries, one per cycle (322560 at defaults)
// a register write recomputes the step reciprocal, busy meanwhile
// results cannot be stalled
module hough_line_accumulator_top import hla_pkg::*; #(
  parameter int THETA_BINS = THETA_BINS_DEF,
  parameter int RHO_BINS   = RHO_BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op_i,
  input  logic [PIX_W-1:0]   pixel_col_i,
  input  logic [PIX_W-1:0]   pixel_row_i,
  input  logic [EDGE_W-1:0]  edge_value_i,
  input  logic [RB_W-1:0]    rho_bin_i,
  input  logic [TB_W-1:0]    theta_bin_i,
  output logic               result_valid_o,
  output logic [CNT_W-1:0]   bin_count_o,
  output logic               bin_missing_o
);

  localparam int TW = (THETA_BINS > 1) ? $clog2(THETA_BINS) : 1;
  localparam int RW = $clog2(RHO_BINS);
  localparam int BW = $clog2(RHO_BINS + 1);
  localparam int AW = TW + RW;
  localparam int DEPTH = THETA_BINS * (1 << RW);
  localparam int TCW = (TW > TB_W) ? TW + 1 : TB_W + 1;
  localparam int RCW = (BW > RB_W) ? BW + 1 : RB_W + 1;

  state_e state_q, state_d;
  logic [STEP_W-1:0]  step_q;
  logic [RMAX_W-1:0]  rmax_q;
  logic [STEP_W-1:0]  step_used;
  logic               cfg_we;
  reg_e               reg_sel;
  logic [TW-1:0]      j_q;
  logic [AW-1:0]      clr_q;
  logic [PIX_W-1:0]   x_q, y_q;
  logic               miss_q;
  logic               rom_v_q;
  logic [TW-1:0]      rom_t_q;
  logic               accept;
  op_e                op;
  logic               in_range;
  logic               rd_en;
  logic               clr_en;
  logic               rom_req;

  logic signed [TRIG_W-1:0] cos_w, sin_w;
  logic               rc_busy;
  logic [RECIP_W-1:0] recip_w;
  logic [BW-1:0]      bins_w;
  logic               calc_v;
  logic [TW-1:0]      calc_theta;
  logic [RW-1:0]      calc_rho;
  logic               calc_active;
  logic [CNT_W-1:0]   rd_data;
  logic               store_pending;

  // configuration port
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_sel = reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_sel)
      REG_STEP: prdata = {{(DATA_W-STEP_W){1'b0}}, step_q};
      REG_RMAX: prdata = {{(DATA_W-RMAX_W){1'b0}}, rmax_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RST;
      rmax_q <= RMAX_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_STEP: step_q <= pwdata[STEP_W-1:0];
        REG_RMAX: rmax_q <= pwdata[RMAX_W-1:0];
        default:  step_q <= step_q;
      endcase
    end
  end

  assign step_used = (step_q == '0) ? STEP_W'(1) : step_q;

  // sequencer
  assign op       = op_e'(op_i);
  assign accept   = start & ~busy;
  assign in_range = (RCW'(rho_bin_i) < RCW'(bins_w))
                  && (TCW'(theta_bin_i) < TCW'(THETA_BINS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_VOTE:  if (edge_value_i != '0) state_d = ST_VOTE;
            OP_READ:  state_d = ST_READ;
            OP_CLEAR: state_d = ST_CLEAR;
            OP_NOP:   state_d = ST_IDLE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_VOTE:  if (j_q == TW'(THETA_BINS - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (!(rom_v_q | calc_active | store_pending)) state_d = ST_IDLE;
      ST_READ:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state_q != ST_IDLE) | rc_busy;
    clr_en         = (state_q == ST_CLEAR);
    rom_req        = (state_q == ST_VOTE);
    rd_en          = accept & (op == OP_READ) & in_range;
    result_valid_o = (state_q == ST_READ);
    bin_count_o    = miss_q ? '0 : rd_data;
    bin_missing_o  = miss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      j_q     <= '0;
      clr_q   <= '0;
      rom_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rom_v_q <= rom_req;
      if (state_q == ST_VOTE) begin
        j_q <= j_q + 1'b1;
      end else begin
        j_q <= '0;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end else begin
        clr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rom_t_q <= j_q;
    if (accept) begin
      x_q    <= pixel_col_i;
      y_q    <= pixel_row_i;
      miss_q <= ~in_range;
    end
  end

  hla_trig_rom #(
    .THETA_BINS (THETA_BINS)
  ) u_trig (
    .clk_i (clk_i),
    .idx_i (j_q),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  hla_recip #(
    .RHO_BINS (RHO_BINS)
  ) u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we),
    .step_i  (step_used),
    .rmax_i  (rmax_q),
    .busy_o  (rc_busy),
    .recip_o (recip_w),
    .bins_o  (bins_w)
  );

  hla_rho_calc #(
    .THETA_BINS (THETA_BINS),
    .RHO_BINS   (RHO_BINS)
  ) u_rho (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .v_i      (rom_v_q),
    .theta_i  (rom_t_q),
    .cos_i    (cos_w),
    .sin_i    (sin_w),
    .x_i      (x_q),
    .y_i      (y_q),
    .rmax_i   (rmax_q),
    .step_i   (step_used),
    .recip_i  (recip_w),
    .bins_i   (bins_w),
    .v_o      (calc_v),
    .theta_o  (calc_theta),
    .rho_o    (calc_rho),
    .active_o (calc_active)
  );

  hla_vote_store #(
    .THETA_BINS (THETA_BINS),
    .RHO_BINS   (RHO_BINS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .inc_v_i    (calc_v),
    .inc_addr_i ({calc_theta, calc_rho}),
    .rd_en_i    (rd_en),
    .rd_addr_i  ({TW'(theta_bin_i), RW'(rho_bin_i)}),
    .clr_en_i   (clr_en),
    .clr_addr_i (clr_q),
    .rd_data_o  (rd_data),
    .pending_o  (store_pending)
  );

  a_result_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && op_i == OP_READ))
    else $error("result without a read item");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!calc_v && !store_pending && !rom_v_q))
    else $error("vote pipeline busy while idle");

  a_clear_no_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en |-> (!store_pending && !calc_v))
    else $error("clear sweep overlaps a vote write");

endmodule

[tb/sv/hough_line_accumulator_top_tb.sv]
// hough_line_accumulator_top_tb: self-checking bench for the hough line vote accumulator,
// with its own trig table and vote store predictor, apb register phases and a random item stream
// depends on hla_pkg and hough_line_accumulator_top
module hough_line_accumulator_top_tb;
  import hla_pkg::*;

  localparam int NTHETA = THETA_BINS_DEF;
  localparam int NRHO = RHO_BINS_DEF;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE = 400;

  typedef struct {
    op_e op;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic [EDGE_W-1:0] edge_val;
    logic [RB_W-1:0] rho;
    logic [TB_W-1:0] theta;
  } cmd_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic missing;
  } bin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] op_i = '0;
  logic [PIX_W-1:0] pixel_col_i = '0;
  logic [PIX_W-1:0] pixel_row_i = '0;
  logic [EDGE_W-1:0] edge_value_i = '0;
  logic [RB_W-1:0] rho_bin_i = '0;
  logic [TB_W-1:0] theta_bin_i = '0;
  logic result_valid_o;
  logic [CNT_W-1:0] bin_count_o;
  logic bin_missing_o;

  hough_line_accumulator_top dut (.*);

  longint cos_tab[NTHETA];
  longint sin_tab[NTHETA];
  logic [CNT_W-1:0] votes[int];
  int unsigned step_q4 = STEP_RST;
  int unsigned rmax = RMAX_RST;
  int unsigned bins_used;
  int hit_bins[$];

  cmd_t pending[$];
  bin_t expected_bins[$];
  cmd_t cur;
  int idle_left = 0;
  int errors = 0;
  int cycles = 0;
  bit fast_phase = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void queue_item(cmd_t c);
    pending.insert(pending.size(), c);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) / (longint'(1) << 30);
  endfunction

  function automatic longint to_q14(longint v);
    if (v >= 0) return (v + 32768) / 65536;
    return -((-v + 32768) / 65536);
  endfunction

  function automatic void build_trig();
    longint one, a, term, c, s, ns;
    one = longint'(1) << 30;
    for (int j = 0; j < NTHETA; j++) begin
      a = (longint'(j) * 67108864 + 50) / 100;
      term = one;
      c = one;
      s = 0;
      for (int k = 1; k <= 14; k++) begin
        term = qmul(term, a) / k;
        case (k % 4)
          1: s += term;
          2: c -= term;
          3: s -= term;
          default: c += term;
        endcase
      end
      for (int n = 0; n < 4; n++) begin
        ns = 2 * qmul(s, c);
        c = 2 * qmul(c, c) - one;
        s = ns;
      end
      cos_tab[j] = to_q14(c);
      sin_tab[j] = to_q14(s);
    end
  endfunction

  function automatic int unsigned eff_step();
    return step_q4 == 0 ? 1 : step_q4;
  endfunction

  function automatic void update_bins_used();
    int unsigned b;
    b = (32 * rmax) / eff_step() + 1;
    bins_used = b > NRHO ? NRHO : b;
  endfunction

  function automatic void cast_votes(int unsigned x, int unsigned y);
    longint d, num, q;
    int key;
    d = longint'(eff_step()) * 1024;
    for (int j = 0; j < NTHETA; j++) begin
      num = longint'(x) * cos_tab[j] + longint'(y) * sin_tab[j] + longint'(rmax) * 16384;
      if (num >= 0) q = (2 * num + d) / (2 * d);
      else q = -((-2 * num + d) / (2 * d));
      if (q < 0 || q >= bins_used) continue;
      key = j * NRHO + int'(q);
      if (!votes.exists(key)) votes[key] = '0;
      if (votes[key] != CNT_MAX) votes[key] = votes[key] + 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        hit_bins.insert(hit_bins.size(), key);
        if (hit_bins.size() > 256) void'(hit_bins.pop_front());
      end
    end
  endfunction

  // expected effect of one accepted item
  function automatic void predict_item(cmd_t c);
    bin_t r;
    int key;
    case (c.op)
      OP_VOTE: if (c.edge_val > 0) cast_votes(c.col, c.row);
      OP_READ: begin
        if (c.rho < bins_used && c.theta < NTHETA) begin
          key = int'(c.theta) * NRHO + int'(c.rho);
          r.count = votes.exists(key) ? votes[key] : '0;
          r.missing = 1'b0;
        end else begin
          r.count = '0;
          r.missing = 1'b1;
        end
        expected_bins.insert(expected_bins.size(), r);
      end
      OP_CLEAR: begin
        votes.delete();
        hit_bins.delete();
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (fast_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_item(cur);
        idle_left = pick_gap();
        if (idle_left == 0 && pending.size() > 0) begin
          cur = pending.pop_front();
          op_i <= cur.op;
          pixel_col_i <= cur.col;
          pixel_row_i <= cur.row;
          edge_value_i <= cur.edge_val;
          rho_bin_i <= cur.rho;
          theta_bin_i <= cur.theta;
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          op_i <= cur.op;
          pixel_col_i <= cur.col;
          pixel_row_i <= cur.row;
          edge_value_i <= cur.edge_val;
          rho_bin_i <= cur.rho;
          theta_bin_i <= cur.theta;
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    bin_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_bins.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result count=%0d missing=%0b",
                                   bin_count_o, bin_missing_o);
      end else begin
        e = expected_bins.pop_front();
        if (bin_count_o !== e.count || bin_missing_o !== e.missing) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected count=%0d missing=%0b, got count=%0d missing=%0b",
                     e.count, e.missing, bin_count_o, bin_missing_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hough_line_accumulator_top test failed");
      $finish;
    end
  end

  function automatic cmd_t mk(op_e op, int col, int row, int ev, int rho, int theta);
    cmd_t c;
    c.op = op;
    c.col = PIX_W'(col);
    c.row = PIX_W'(row);
    c.edge_val = EDGE_W'(ev);
    c.rho = RB_W'(rho);
    c.theta = TB_W'(theta);
    return c;
  endfunction

  function automatic cmd_t random_item();
    int r, key;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return mk(OP_VOTE,
                $urandom_range(0, 19) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 256),
                $urandom_range(0, 19) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 256),
                $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 255),
                $urandom_range(0, 1023), $urandom_range(0, 511));
    end
    if (r < 75 && hit_bins.size() > 0) begin
      key = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
      return mk(OP_READ, $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 255), key % NRHO, key / NRHO);
    end
    if (r < 97) begin
      return mk(OP_READ, $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 255), $urandom_range(0, 1023),
                $urandom_range(0, 9) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 314));
    end
    return mk(OP_NOP, $urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(0, 511));
  endfunction

  task automatic drain();
    while (pending.size() > 0 || start || expected_bins.size() > 0 || busy)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(idx) * 4);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_STEP) step_q4 = val[STEP_W-1:0];
    else rmax = val[RMAX_W-1:0];
    update_bins_used();
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) fast_phase = ($urandom_range(0, 3) == 0);
      queue_item(random_item());
    end
    drain();
  endtask

  initial begin
    build_trig();
    update_bins_used();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, edge value zero, odd ops, out of range reads, clear
    queue_item(mk(OP_VOTE, 1, 1, 255, 0, 0));
    queue_item(mk(OP_VOTE, 256, 256, 1, 1023, 511));
    queue_item(mk(OP_VOTE, 256, 1, 128, 0, 0));
    queue_item(mk(OP_VOTE, 1, 256, 7, 0, 0));
    queue_item(mk(OP_VOTE, 128, 128, 0, 0, 0));
    queue_item(mk(OP_VOTE, 0, 0, 9, 0, 0));
    queue_item(mk(OP_VOTE, 511, 511, 255, 0, 0));
    queue_item(mk(OP_NOP, 511, 511, 255, 1023, 511));
    queue_item(mk(OP_READ, 0, 0, 0, 0, 0));
    queue_item(mk(OP_READ, 0, 0, 0, 1023, 0));
    queue_item(mk(OP_READ, 0, 0, 0, 726, 314));
    queue_item(mk(OP_READ, 0, 0, 0, 727, 0));
    queue_item(mk(OP_READ, 0, 0, 0, 100, 315));
    queue_item(mk(OP_READ, 0, 0, 0, 100, 511));
    drain();
    for (int i = 0; i < 8 && hit_bins.size() > 0; i++)
      queue_item(mk(OP_READ, 0, 0, 0, hit_bins[i] % NRHO, hit_bins[i] / NRHO));
    queue_item(mk(OP_CLEAR, 511, 511, 255, 1023, 511));
    queue_item(mk(OP_READ, 0, 0, 0, 363, 0));
    queue_item(mk(OP_READ, 0, 0, 0, 0, 314));
    drain();

    run_random(500);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_RMAX, 32'd1);
    run_random(250);
    write_reg(REG_STEP, 32'd1);
    write_reg(REG_RMAX, 32'd363);
    run_random(300);
    write_reg(REG_STEP, 32'd0);
    write_reg(REG_RMAX, 32'd200);
    run_random(250);
    write_reg(REG_STEP, 32'd7);
    write_reg(REG_RMAX, 32'h0000_FEAA);
    run_random(300);

    if (errors == 0) begin
      $display("hough_line_accumulator_top test passed");
    end else begin
      $display("hough_line_accumulator_top test failed");
    end
    $finish;
  end

endmodule
